// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// antecedent implies consequent after the delay dly
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("assertion failed: delayed response");

`endif

// ===== rtl/core/ssb_pkg.sv =====
// ----------------------------------------------------------------------------
// ssb_pkg
// Widths, constants and the front-end beat type of the slice bounds block.
// ----------------------------------------------------------------------------
package ssb_pkg;

	// range position width (signed)
	localparam int POS_W    = 61;
	// stride width (signed)
	localparam int STRIDE_W = 62;
	// divisor and count-dividend width
	localparam int DIV_W    = 62;
	// dividend width of the start-alignment divider
	localparam int NUM_W    = 61;
	// working width of position sums
	localparam int SUM_W    = 63;
	// lengths above this cannot change any result
	localparam logic [63:0] LEN_CAP = 64'h2000_0000_0000_0000;

	// fields decoded at the front and carried past the first divider
	typedef struct packed {
		logic signed [STRIDE_W-1:0] step;
		logic [DIV_W-1:0]           len;
		logic signed [POS_W-1:0]    first;
		logic signed [POS_W-1:0]    last;
		logic                       pos;
		logic                       early_empty;
		logic                       adj;
		logic                       alias_ok;
	} ssb_front_t;

endpackage

// ===== rtl/core/ssb_div_cell.sv =====
// ----------------------------------------------------------------------------
// ssb_div_cell
// One restoring division step: shifts in one dividend bit, yields one quotient bit.
// ----------------------------------------------------------------------------
module ssb_div_cell import ssb_pkg::*; #(
	parameter int NW   = 61,
	parameter int SB_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [DIV_W-1:0] in_rem,
	input  logic [NW-1:0]    in_num,
	input  logic [DIV_W-1:0] in_div,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [DIV_W-1:0] out_rem,
	output logic [NW-1:0]    out_num,
	output logic [DIV_W-1:0] out_div,
	output logic [SB_W-1:0]  out_sb
);

	logic [DIV_W:0] trial;
	logic [DIV_W:0] dvs;
	logic [DIV_W:0] diff;
	logic           fits;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {in_rem, in_num[NW-1]};
		dvs   = {1'b0, in_div};
		diff  = trial - dvs;
		fits  = (trial >= dvs);
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// payload hand-off to the next cell
	always_ff @(posedge clk) begin
		out_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		out_num <= {in_num[NW-2:0], fits};
		out_div <= in_div;
		out_sb  <= in_sb;
	end

endmodule

// ===== rtl/core/ssb_div_chain.sv =====
// ----------------------------------------------------------------------------
// ssb_div_chain
// Row of division cells, one quotient bit per cell, one beat entering per cycle.
// ----------------------------------------------------------------------------
module ssb_div_chain import ssb_pkg::*; #(
	parameter int NW   = 61,
	parameter int SB_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NW-1:0]    in_num,
	input  logic [DIV_W-1:0] in_div,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [DIV_W-1:0] out_rem,
	output logic [NW-1:0]    out_quo,
	output logic [DIV_W-1:0] out_div,
	output logic [SB_W-1:0]  out_sb
);

	logic             valid_c [0:NW];
	logic [DIV_W-1:0] rem_c   [0:NW];
	logic [NW-1:0]    num_c   [0:NW];
	logic [DIV_W-1:0] div_c   [0:NW];
	logic [SB_W-1:0]  sb_c    [0:NW];

	// head of the row starts with an empty remainder
	assign valid_c[0] = in_valid;
	assign rem_c[0]   = '0;
	assign num_c[0]   = in_num;
	assign div_c[0]   = in_div;
	assign sb_c[0]    = in_sb;

	// cells
	for (genvar i = 0; i < NW; i++) begin : g_cell
		ssb_div_cell #(
			.NW   (NW),
			.SB_W (SB_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_rem    (rem_c[i]),
			.in_num    (num_c[i]),
			.in_div    (div_c[i]),
			.in_sb     (sb_c[i]),
			.out_valid (valid_c[i+1]),
			.out_rem   (rem_c[i+1]),
			.out_num   (num_c[i+1]),
			.out_div   (div_c[i+1]),
			.out_sb    (sb_c[i+1])
		);
	end

	// tail of the row
	assign out_valid = valid_c[NW];
	assign out_rem   = rem_c[NW];
	assign out_quo   = num_c[NW];
	assign out_div   = div_c[NW];
	assign out_sb    = sb_c[NW];

endmodule

// ===== rtl/core/strided_slice_bounds.sv =====
// ----------------------------------------------------------------------------
// strided_slice_bounds
// Slice descriptor (start, stride, count, sharing) of a list over a stepped range.
// ----------------------------------------------------------------------------
//
//  channel | handshake     | payload
//  --------+---------------+-------------------------------------------------
//  in      | start / busy  | range_first range_next range_last list_length
//          |               | aliasing_allowed
//  out     | done          | start_index stride element_count shares_storage
//
// one beat accepted every cycle; busy is held low
// the path holds the input, clamp, span and result registers and two rows of division cells in series:
// 61 cells align the start onto the stride grid, 62 cells divide out the count
// reset clears the valid flags of every stage; payload registers are not reset
// results are shown for one cycle under done; the receiver cannot stall
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strided_slice_bounds import ssb_pkg::*; #(
	parameter int INDEX_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [POS_W-1:0]    range_first,
	input  logic signed [POS_W-1:0]    range_next,
	input  logic signed [POS_W-1:0]    range_last,
	input  logic [INDEX_WIDTH-1:0]     list_length,
	input  logic                       aliasing_allowed,
	output logic                       done,
	output logic [INDEX_WIDTH-1:0]     start_index,
	output logic signed [STRIDE_W-1:0] stride,
	output logic [INDEX_WIDTH-1:0]     element_count,
	output logic                       shares_storage
);

	localparam int LAT = 4 + NUM_W + DIV_W;
	localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1);

	typedef struct packed {
		logic signed [STRIDE_W-1:0] step;
		logic [INDEX_WIDTH-1:0]     start;
		logic                       empty;
		logic                       alias_ok;
	} ssb_back_t;

	localparam int FRONT_W = $bits(ssb_front_t);
	localparam int BACK_W  = $bits(ssb_back_t);

	assign busy = 1'b0;

	// front decode
	logic signed [SUM_W-1:0] first_x, next_x, last_x, len_x, step_x, num_x, mag_x;
	logic [63:0]             ulen;
	logic [DIV_W-1:0]        len_c;
	logic                    pos_c, neg_c;
	ssb_front_t              front_c;

	always_comb begin
		first_x = SUM_W'(range_first);
		next_x  = SUM_W'(range_next);
		last_x  = SUM_W'(range_last);
		step_x  = next_x - first_x;
		ulen    = 64'(list_length);
		len_c   = (ulen > LEN_CAP) ? LEN_CAP[DIV_W-1:0] : ulen[DIV_W-1:0];
		len_x   = SUM_W'({1'b0, len_c});
		pos_c   = (step_x > 0);
		neg_c   = (step_x < 0);
		mag_x   = neg_c ? -step_x : step_x;
		// distance whose remainder by the step magnitude fixes the start
		num_x   = pos_c ? -first_x : (first_x - len_x - ONE);
		front_c.step        = step_x[STRIDE_W-1:0];
		front_c.len         = len_c;
		front_c.first       = range_first;
		front_c.last        = range_last;
		front_c.pos         = pos_c;
		front_c.early_empty = (step_x == 0) || (pos_c && (first_x > len_x))
			|| (neg_c && (first_x < ONE));
		front_c.adj         = pos_c ? (first_x < ONE) : (first_x > len_x);
		front_c.alias_ok    = aliasing_allowed;
	end

	// input stage
	logic             valid_s1;
	ssb_front_t       front_s1;
	logic [NUM_W-1:0] num_s1;
	logic [DIV_W-1:0] mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		front_s1 <= front_c;
		num_s1   <= num_x[NUM_W-1:0];
		mag_s1   <= mag_x[DIV_W-1:0];
	end

	// start alignment remainder
	logic               valid_a;
	logic [DIV_W-1:0]   rem_a;
	logic [DIV_W-1:0]   mag_a;
	logic [FRONT_W-1:0] sb_a;
	ssb_front_t         front_a;

	ssb_div_chain #(
		.NW   (NUM_W),
		.SB_W (FRONT_W)
	) u_align (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_num    (num_s1),
		.in_div    (mag_s1),
		.in_sb     (front_s1),
		.out_valid (valid_a),
		.out_rem   (rem_a),
		.out_quo   (),
		.out_div   (mag_a),
		.out_sb    (sb_a)
	);

	assign front_a = ssb_front_t'(sb_a);

	// clamp start and end into the list
	logic signed [SUM_W-1:0] r2_x, m2_x, l2_x, f2_x, e2_x, first_c2, last_c2;

	always_comb begin
		r2_x = SUM_W'({1'b0, rem_a});
		m2_x = SUM_W'({1'b0, mag_a});
		l2_x = SUM_W'({1'b0, front_a.len});
		f2_x = SUM_W'(front_a.first);
		e2_x = SUM_W'(front_a.last);
		if (!front_a.adj) begin
			first_c2 = f2_x;
		end else if (front_a.pos) begin
			first_c2 = m2_x - r2_x;
		end else begin
			first_c2 = l2_x + ONE + r2_x - m2_x;
		end
		if (front_a.pos) begin
			last_c2 = (e2_x > l2_x) ? l2_x : e2_x;
		end else begin
			last_c2 = (e2_x < ONE) ? ONE : e2_x;
		end
	end

	logic                       valid_s2;
	logic signed [SUM_W-1:0]    first_s2, last_s2;
	logic signed [STRIDE_W-1:0] step_s2;
	logic                       pos_s2, early_s2, alias_s2;
	logic [DIV_W-1:0]           mag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_a;
		end
	end

	always_ff @(posedge clk) begin
		first_s2 <= first_c2;
		last_s2  <= last_c2;
		step_s2  <= front_a.step;
		pos_s2   <= front_a.pos;
		early_s2 <= front_a.early_empty;
		alias_s2 <= front_a.alias_ok;
		mag_s2   <= mag_a;
	end

	// emptiness and span to divide
	logic signed [SUM_W-1:0] dist_c3;
	logic [63:0]             first_w3;
	ssb_back_t               back_c3;

	always_comb begin
		dist_c3  = pos_s2 ? (last_s2 - first_s2) : (first_s2 - last_s2);
		first_w3 = 64'(first_s2);
		back_c3.step     = step_s2;
		back_c3.start    = first_w3[INDEX_WIDTH-1:0];
		back_c3.empty    = early_s2 || (pos_s2 ? (last_s2 < first_s2) : (last_s2 > first_s2));
		back_c3.alias_ok = alias_s2;
	end

	logic             valid_s3;
	logic [DIV_W-1:0] dist_s3;
	logic [DIV_W-1:0] mag_s3;
	ssb_back_t        back_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dist_s3 <= dist_c3[DIV_W-1:0];
		mag_s3  <= mag_s2;
		back_s3 <= back_c3;
	end

	// element count division
	logic              valid_b;
	logic [DIV_W-1:0]  quo_b;
	logic [BACK_W-1:0] sb_b;
	ssb_back_t         back_b;

	ssb_div_chain #(
		.NW   (DIV_W),
		.SB_W (BACK_W)
	) u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_num    (dist_s3),
		.in_div    (mag_s3),
		.in_sb     (back_s3),
		.out_valid (valid_b),
		.out_rem   (),
		.out_quo   (quo_b),
		.out_div   (),
		.out_sb    (sb_b)
	);

	assign back_b = ssb_back_t'(sb_b);

	// result stage
	logic [63:0] count_w;

	assign count_w = 64'(quo_b) + 64'd1;

	logic                       done_s4;
	logic [INDEX_WIDTH-1:0]     start_s4, count_s4;
	logic signed [STRIDE_W-1:0] stride_s4;
	logic                       share_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= valid_b;
		end
	end

	always_ff @(posedge clk) begin
		start_s4  <= back_b.empty ? '0 : back_b.start;
		count_s4  <= back_b.empty ? '0 : count_w[INDEX_WIDTH-1:0];
		stride_s4 <= back_b.step;
		share_s4  <= !back_b.empty && (back_b.step == STRIDE_W'(1)) && back_b.alias_ok;
	end

	assign done           = done_s4;
	assign start_index    = start_s4;
	assign element_count  = count_s4;
	assign stride         = stride_s4;
	assign shares_storage = share_s4;

	// checks
	`ASSERT_IMPLY(a_empty_clean, clk, arst_n, done && (start_index == '0), (element_count == '0) && !shares_storage)
	`ASSERT_IMPLY(a_share_unit, clk, arst_n, done && shares_storage, stride == STRIDE_W'(1))
	`ASSERT_DELAY(a_latency, clk, arst_n, start && !busy, LAT, done)

endmodule
